FILE: hdl/mkfvs_pkg.sv
package mkfvs_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int PATTERN_W  = 64;
   localparam int K_LIMIT    = (MAX_WINDOW < PATTERN_W) ? MAX_WINDOW : PATTERN_W;

   localparam int PTR_W     = 6;
   localparam int CNT_W     = 7;
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 2;
   localparam int TECH_W    = 3;
   localparam int CMD_W     = 2;
   localparam int VER_W     = 2;

   localparam logic [CNT_W-1:0] K_LIMIT_V = CNT_W'(K_LIMIT);

   typedef enum logic [CMD_W-1:0] {
      CMD_JOB       = 2'd0,
      CMD_REPORT    = 2'd1,
      CMD_START     = 2'd2,
      CMD_REPLENISH = 2'd3
   } cmd_type;

   localparam logic [TECH_W-1:0] TECH_NONE          = 3'd0;
   localparam logic [TECH_W-1:0] TECH_STATIC_RETRY  = 3'd1;
   localparam logic [TECH_W-1:0] TECH_STATIC_DETECT = 3'd2;
   localparam logic [TECH_W-1:0] TECH_DYN_RETRY     = 3'd3;
   localparam logic [TECH_W-1:0] TECH_DYN_DETECT    = 3'd4;

   localparam logic [VER_W-1:0] VER_BASIC   = 2'd0;
   localparam logic [VER_W-1:0] VER_DETECT  = 2'd1;
   localparam logic [VER_W-1:0] VER_CORRECT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_REQUIRED_M  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_K    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TECHNIQUE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_KIND = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic exec;
      logic build_init;
      logic build_step;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic starts_build;
      logic build_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: hdl/mkfvs_ifs.sv
interface mkfvs_req_if;
   import mkfvs_pkg::*;

   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic             fault_seen;

   modport source (output valid, output cmd, output fault_seen, input ready);
   modport sink (input valid, input cmd, input fault_seen, output ready);
endinterface

interface mkfvs_rsp_if;
   import mkfvs_pkg::*;

   logic             valid;
   logic             ready;
   logic             release_res;
   logic [VER_W-1:0] version;
   logic             rejected;

   modport source (output valid, output release_res, output version, output rejected,
                   input ready);
   modport sink (input valid, input release_res, input version, input rejected,
                 output ready);
endinterface

FILE: hdl/mkfvs_dp.sv
module mkfvs_dp import mkfvs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic                 req_fault_seen,
   input  dp_cmd_type           dp_cmd,
   output dp_status_type        dp_status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_release_res,
   output logic [VER_W-1:0]     rsp_version,
   output logic                 rsp_rejected
);

   logic [CNT_W-1:0]     required_m_ff, required_m_in;
   logic [CNT_W-1:0]     window_k_ff, window_k_in;
   logic [TECH_W-1:0]    technique_ff, technique_in;
   logic                 pattern_kind_ff, pattern_kind_in;

   logic [PATTERN_W-1:0] pattern_ff, pattern_in;
   logic [PTR_W-1:0]     bit_pointer_ff, bit_pointer_in;
   logic [CNT_W-1:0]     zero_tol_ff, zero_tol_in;
   logic [CNT_W-1:0]     one_tol_ff, one_tol_in;
   logic [CNT_W-1:0]     zero_reload_ff, zero_reload_in;
   logic [CNT_W-1:0]     one_reload_ff, one_reload_in;

   logic [PTR_W-1:0]     j_ff, j_in;
   logic [CNT_W-1:0]     r_ff, r_in;
   logic                 in_ones_ff, in_ones_in;
   logic                 done_ff, done_in;

   logic                 res_rel_ff, res_rel_in;
   logic [VER_W-1:0]     res_ver_ff, res_ver_in;
   logic                 res_rej_ff, res_rej_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_rel_ff, out_rel_in;
   logic [VER_W-1:0]     out_ver_ff, out_ver_in;
   logic                 out_rej_ff, out_rej_in;

   logic [CNT_W-1:0]     eff_k;
   logic                 m_gt_k;
   logic [CNT_W-1:0]     zeros;
   logic                 is_static, is_dynamic;
   logic [CNT_W-1:0]     ptr_inc;
   logic [CNT_W-1:0]     j_ext;
   logic                 bit_one;
   logic [CNT_W:0]       r_sum;
   logic [CNT_W:0]       r_wrap;
   logic [CNT_W-1:0]     zr_step, or_step;
   logic                 in_ones_step, done_step;

   // effective window: 0 reads as 1, saturate at the limit
   always_comb begin
      if (window_k_ff == '0) begin
         eff_k = CNT_W'(1);
      end else if (window_k_ff > K_LIMIT_V) begin
         eff_k = K_LIMIT_V;
      end else begin
         eff_k = window_k_ff;
      end
   end

   assign m_gt_k     = required_m_ff > eff_k;
   assign zeros      = eff_k - required_m_ff;
   assign is_static  = (technique_ff == TECH_STATIC_RETRY) || (technique_ff == TECH_STATIC_DETECT);
   assign is_dynamic = (technique_ff == TECH_DYN_RETRY) || (technique_ff == TECH_DYN_DETECT);
   assign ptr_inc    = {1'b0, bit_pointer_ff} + CNT_W'(1);
   assign j_ext      = {1'b0, j_ff};

   // E pattern: r tracks (j*z) mod k; bit 0 if z>0 and (r=0 or k-r<z)
   always_comb begin
      if (!pattern_kind_ff) begin
         bit_one = j_ext >= zeros;
      end else begin
         bit_one = (zeros == '0) || ((r_ff != '0) && ((eff_k - r_ff) >= zeros));
      end
   end

   assign r_sum  = {1'b0, r_ff} + {1'b0, zeros};
   assign r_wrap = (r_sum >= {1'b0, eff_k}) ? (r_sum - {1'b0, eff_k}) : r_sum;

   // leading zero run, then the first run of ones
   always_comb begin
      zr_step      = zero_reload_ff;
      or_step      = one_reload_ff;
      in_ones_step = in_ones_ff;
      done_step    = done_ff;
      if (!done_ff) begin
         if (!bit_one) begin
            if (in_ones_ff) begin
               done_step = 1'b1;
            end else begin
               zr_step = zero_reload_ff + CNT_W'(1);
            end
         end else begin
            in_ones_step = 1'b1;
            or_step      = one_reload_ff + CNT_W'(1);
         end
      end
   end

   assign dp_status.starts_build = (cmd_type'(req_cmd) == CMD_START) && !m_gt_k;
   assign dp_status.build_last   = j_ext == (eff_k - CNT_W'(1));
   assign dp_status.out_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      required_m_in   = required_m_ff;
      window_k_in     = window_k_ff;
      technique_in    = technique_ff;
      pattern_kind_in = pattern_kind_ff;
      pattern_in      = pattern_ff;
      bit_pointer_in  = bit_pointer_ff;
      zero_tol_in     = zero_tol_ff;
      one_tol_in      = one_tol_ff;
      zero_reload_in  = zero_reload_ff;
      one_reload_in   = one_reload_ff;
      j_in            = j_ff;
      r_in            = r_ff;
      in_ones_in      = in_ones_ff;
      done_in         = done_ff;
      res_rel_in      = res_rel_ff;
      res_ver_in      = res_ver_ff;
      res_rej_in      = res_rej_ff;
      rsp_valid_in    = rsp_valid_ff;
      out_rel_in      = out_rel_ff;
      out_ver_in      = out_ver_ff;
      out_rej_in      = out_rej_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_REQUIRED_M:   required_m_in   = csr_wdata;
            CSR_WINDOW_K:     window_k_in     = csr_wdata;
            CSR_TECHNIQUE:    technique_in    = csr_wdata[TECH_W-1:0];
            CSR_PATTERN_KIND: pattern_kind_in = csr_wdata[0];
         endcase
      end

      if (dp_cmd.exec) begin
         res_rel_in = 1'b0;
         res_ver_in = VER_BASIC;
         res_rej_in = 1'b0;
         unique case (cmd_type'(req_cmd))
            CMD_JOB: begin
               res_rel_in = 1'b1;
               if (is_static) begin
                  bit_pointer_in = (ptr_inc >= eff_k) ? '0 : ptr_inc[PTR_W-1:0];
                  if (pattern_ff[bit_pointer_ff]) begin
                     res_ver_in = (technique_ff == TECH_STATIC_RETRY) ? VER_CORRECT
                                                                      : VER_DETECT;
                  end
               end else if (is_dynamic) begin
                  if (zero_tol_ff != '0) begin
                     res_ver_in = VER_DETECT;
                  end else begin
                     res_ver_in = (technique_ff == TECH_DYN_RETRY) ? VER_CORRECT : VER_DETECT;
                     if (one_tol_ff != '0) begin
                        one_tol_in = one_tol_ff - CNT_W'(1);
                     end
                  end
               end
            end
            CMD_REPORT: begin
               if (req_fault_seen) begin
                  if (technique_ff == TECH_STATIC_DETECT) begin
                     res_rel_in = 1'b1;
                     res_ver_in = VER_CORRECT;
                  end else if (is_dynamic) begin
                     if (zero_tol_ff != '0) begin
                        zero_tol_in = zero_tol_ff - CNT_W'(1);
                     end else begin
                        res_rel_in = 1'b1;
                        res_ver_in = VER_CORRECT;
                     end
                  end
               end
            end
            CMD_START: begin
               res_rej_in = m_gt_k;
            end
            CMD_REPLENISH: begin
               zero_tol_in = zero_reload_ff;
               one_tol_in  = one_reload_ff;
            end
         endcase
      end

      if (dp_cmd.build_init) begin
         pattern_in     = '0;
         bit_pointer_in = '0;
         zero_reload_in = '0;
         one_reload_in  = '0;
         j_in           = '0;
         r_in           = '0;
         in_ones_in     = 1'b0;
         done_in        = 1'b0;
      end

      if (dp_cmd.build_step) begin
         pattern_in[j_ff] = bit_one;
         zero_reload_in   = zr_step;
         one_reload_in    = or_step;
         in_ones_in       = in_ones_step;
         done_in          = done_step;
         r_in             = r_wrap[CNT_W-1:0];
         j_in             = j_ff + PTR_W'(1);
         if (dp_status.build_last) begin
            zero_tol_in = zr_step;
            one_tol_in  = or_step;
         end
      end

      if (dp_cmd.load_out) begin
         rsp_valid_in = 1'b1;
         out_rel_in   = res_rel_ff;
         out_ver_in   = res_ver_ff;
         out_rej_in   = res_rej_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         required_m_ff   <= CNT_W'(1);
         window_k_ff     <= CNT_W'(1);
         technique_ff    <= TECH_NONE;
         pattern_kind_ff <= 1'b0;
         pattern_ff      <= '0;
         bit_pointer_ff  <= '0;
         zero_tol_ff     <= '0;
         one_tol_ff      <= '0;
         zero_reload_ff  <= '0;
         one_reload_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         required_m_ff   <= required_m_in;
         window_k_ff     <= window_k_in;
         technique_ff    <= technique_in;
         pattern_kind_ff <= pattern_kind_in;
         pattern_ff      <= pattern_in;
         bit_pointer_ff  <= bit_pointer_in;
         zero_tol_ff     <= zero_tol_in;
         one_tol_ff      <= one_tol_in;
         zero_reload_ff  <= zero_reload_in;
         one_reload_ff   <= one_reload_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff       <= j_in;
      r_ff       <= r_in;
      in_ones_ff <= in_ones_in;
      done_ff    <= done_in;
      res_rel_ff <= res_rel_in;
      res_ver_ff <= res_ver_in;
      res_rej_ff <= res_rej_in;
      out_rel_ff <= out_rel_in;
      out_ver_ff <= out_ver_in;
      out_rej_ff <= out_rej_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_release_res = out_rel_ff;
   assign rsp_version     = out_ver_ff;
   assign rsp_rejected    = out_rej_ff;

   a_build_only_when_fits: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.build_step |-> !m_gt_k)
      else $error("pattern build running with m above k");

   a_pointer_cleared_by_build: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.build_step && dp_status.build_last) |=> (bit_pointer_ff == '0))
      else $error("bit pointer not cleared after build");

   a_reloads_fit_window: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.build_step && dp_status.build_last) |=>
         (({1'b0, zero_reload_ff} + {1'b0, one_reload_ff}) <= {1'b0, eff_k}))
      else $error("tolerance reloads exceed window");

endmodule

FILE: hdl/mkfvs_ctrl.sv
module mkfvs_ctrl import mkfvs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    dp_cmd,
   input  dp_status_type dp_status
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.exec = 1'b1;
               if (dp_status.starts_build) begin
                  dp_cmd.build_init = 1'b1;
                  state_in          = ST_BUILD;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_BUILD: begin
            // one pattern bit per cycle
            dp_cmd.build_step = 1'b1;
            if (dp_status.build_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (dp_status.out_free) begin
               dp_cmd.load_out = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/mk_firm_version_selector.sv
// (m,k)-firm version selector for one protected task. Each request word carries a command:
// job request, end-of-detection report, start (build the k-bit pattern from required_m,
// window_k and pattern_kind, or reject it when required_m exceeds the window) or
// replenish; each produces exactly one response word with the release flag, the version
// and the start-rejected flag. A word's result is registered, then copied into the
// response register once it is free; a start word that is not rejected first runs the build
// walk over the effective window k, which produces one pattern bit per cycle and the
// tolerance reload counts. One word is in work at a time; a finished response may wait in
// the output register while the next word is accepted, and a word whose response finds it
// still full waits until it drains. Registers are written through csr_we/csr_index/csr_wdata;
// the user must write them only while no word is in work, which the block does not enforce.
module mk_firm_version_selector import mkfvs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mkfvs_req_if.sink            req_chan,
   mkfvs_rsp_if.source          rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   mkfvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   mkfvs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_chan.cmd),
      .req_fault_seen  (req_chan.fault_seen),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_release_res (rsp_chan.release_res),
      .rsp_version     (rsp_chan.version),
      .rsp_rejected    (rsp_chan.rejected)
   );

endmodule
